// ===== src/pctdec_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the hex-digit classifier of the percent decoder.
// No dependencies; every other file of the block imports this package.
package pctdec_pkg;

   localparam logic [7:0] PCT_CHAR = 8'h25;
   localparam logic [3:0] HEX_TEN = 4'd10;
   localparam int unsigned ENTRY_BYTES = 3;
   localparam int unsigned QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   // One classified input item: up to three bytes; the last flag belongs to the final byte.
   typedef struct packed {
      logic [1:0]                  count;
      logic                        last;
      logic [ENTRY_BYTES-1:0][7:0] bytes;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic       bad;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_of(input logic [7:0] b);
      hex_type h;
      h.bad = 1'b0;
      h.value = 4'd0;
      priority if (b >= 8'h30 && b <= 8'h39) begin
         h.value = 4'(b - 8'h30);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         h.value = 4'(b - 8'h41) + HEX_TEN;
      end else if (b >= 8'h61 && b <= 8'h66) begin
         h.value = 4'(b - 8'h61) + HEX_TEN;
      end else begin
         h.bad = 1'b1;
      end
      return h;
   endfunction

endpackage

// ===== src/pctdec_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts raw bytes, tracks a pending escape and classifies each
// byte into a queue entry of zero to three output bytes. Depends on pctdec_pkg.
module pctdec_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  pctdec_pkg::req_type         req_payload,
   input  pctdec_pkg::queue_status_type status,
   output logic                        push,
   output pctdec_pkg::entry_type       entry
);
   import pctdec_pkg::*;

   typedef enum logic [1:0] {
      PEND_NONE  = 2'd0,
      PEND_PCT   = 2'd1,
      PEND_DIGIT = 2'd2
   } pend_type;

   pend_type   pend_ff, pend_in;
   logic [7:0] digit_ff, digit_in;
   hex_type    hex_b, hex_p;
   logic       accept;
   logic [1:0] fresh_pos;
   logic       do_fresh;

   assign req_ready = !status.full;
   assign accept    = req_valid && req_ready;
   assign hex_b     = hex_of(req_payload.in_byte);
   assign hex_p     = hex_of(digit_ff);

   always_comb begin
      pend_in     = pend_ff;
      digit_in    = digit_ff;
      entry.count = 2'd0;
      entry.last  = req_payload.in_last;
      entry.bytes = '0;
      do_fresh    = 1'b0;
      fresh_pos   = 2'd0;
      unique case (pend_ff)
         PEND_PCT: begin
            if (!req_payload.in_last && !hex_b.bad) begin
               digit_in = req_payload.in_byte;
               pend_in  = PEND_DIGIT;
            end else begin
               entry.bytes[0] = PCT_CHAR;
               do_fresh       = 1'b1;
               fresh_pos      = 2'd1;
            end
         end
         PEND_DIGIT: begin
            if (!hex_b.bad && !hex_p.bad) begin
               entry.bytes[0] = {hex_p.value, hex_b.value};
               entry.count    = 2'd1;
               pend_in        = PEND_NONE;
            end else begin
               entry.bytes[0] = PCT_CHAR;
               entry.bytes[1] = digit_ff;
               do_fresh       = 1'b1;
               fresh_pos      = 2'd2;
            end
         end
         default: begin
            do_fresh  = 1'b1;
            fresh_pos = 2'd0;
         end
      endcase
      // A fresh byte either becomes a new pending '%' or is passed on as is.
      if (do_fresh) begin
         if (req_payload.in_byte == PCT_CHAR && !req_payload.in_last) begin
            pend_in     = PEND_PCT;
            entry.count = fresh_pos;
         end else begin
            entry.bytes[fresh_pos] = req_payload.in_byte;
            entry.count            = fresh_pos + 2'd1;
            pend_in                = PEND_NONE;
         end
      end
   end

   assign push = accept && (entry.count != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= PEND_NONE;
      end else if (accept) begin
         pend_ff <= pend_in;
      end
      if (accept) begin
         digit_ff <= digit_in;
      end
   end

endmodule

// ===== src/pctdec_queue.sv =====
`timescale 1ns / 1ps
// Two-entry queue of classified entries between the front and back ends.
// Depends on pctdec_pkg.
module pctdec_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  pctdec_pkg::entry_type        push_entry,
   input  logic                         pop,
   output pctdec_pkg::entry_type        head,
   output pctdec_pkg::queue_status_type status
);
   import pctdec_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== src/pctdec_back.sv =====
`timescale 1ns / 1ps
// Back end: walks the bytes of the head queue entry one per cycle, while the
// receiver is ready, into a registered result stage. Depends on pctdec_pkg.
module pctdec_back (
   input  logic                         clock,
   input  logic                         reset,
   input  pctdec_pkg::entry_type        head,
   input  pctdec_pkg::queue_status_type status,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output pctdec_pkg::rsp_type          rsp_payload
);
   import pctdec_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_payload_ff, rsp_payload_in;
   logic       load, at_end;

   assign load   = !rsp_valid_ff || rsp_ready;
   assign at_end = (idx_ff == head.count - 2'd1);
   assign pop    = load && !status.empty && at_end;

   always_comb begin
      idx_in         = idx_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (load) begin
         rsp_valid_in = !status.empty;
         if (!status.empty) begin
            rsp_payload_in.out_byte = head.bytes[idx_ff];
            rsp_payload_in.out_last = head.last && at_end;
            idx_in                  = at_end ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ===== src/percent_decoder_core.sv =====
`timescale 1ns / 1ps
// Streaming URL percent decoder.
// Input channel (req_): one raw byte per transfer with a last-of-string flag.
// Output channel (rsp_): one decoded or literal byte per transfer, the final
// byte of each string flagged by out_last.
// A '%' and two hex digits (either case) become one byte. A '%' followed by a
// non-hex byte, or cut short by the end of the string, is passed literally,
// together with any held digit, and the bytes after it are examined again.
// Throughput: one input byte per cycle while each byte yields at most one
// output byte and the receiver is ready; the output side sends one byte per
// cycle, so an input that flushes a held '%' and digit gives two or three
// output bytes; the two-entry queue between classifier and output absorbs that.
// An input's first result passes through the queue register and then the
// output register before it is offered on rsp_.
// Reset clears the pending escape, the queue and the output register.
// When the receiver stalls, the result is held in the output register, the
// queue fills and req_ready drops once both queue entries are taken.
// Depends on pctdec_pkg, pctdec_front, pctdec_queue and pctdec_back.
module percent_decoder_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pctdec_pkg::req_type req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output pctdec_pkg::rsp_type rsp_payload
);
   import pctdec_pkg::*;

   entry_type        push_entry, head;
   logic             push, pop;
   queue_status_type status;

   pctdec_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .status      (status),
      .push        (push),
      .entry       (push_entry)
   );

   pctdec_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (status)
   );

   pctdec_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .status      (status),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== src/pctdec_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for percent_decoder_core, attached by the bind below.
// Depends on pctdec_pkg.
module pctdec_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input pctdec_pkg::req_type req_payload,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input pctdec_pkg::rsp_type rsp_payload
);
   import pctdec_pkg::*;

   // A stalled result transfer keeps its data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp payload changed while stalled");

   // Reset empties the output stage.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // Reset empties the queue, so input is taken right away.
   assert property (@(posedge clock) $past(reset) |-> req_ready)
      else $error("req_ready low right after reset");

   // A byte taken by the empty block right after reset does not show up in the cycle after its transfer.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) && req_valid && req_ready |=> !rsp_valid)
      else $error("result appeared too early after reset");

endmodule

bind percent_decoder_core pctdec_checker u_pctdec_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for percent_decoder_core: directed escapes, broken and
// short escapes, then random strings, checked against row results or an in-bench decoder.
// Depends on pctdec_pkg and the percent_decoder_core RTL.
module tb;
   import pctdec_pkg::*;

   localparam int HALF_PERIOD = 5;
   localparam int RESET_CYCLES = 9;
   localparam int RANDOM_ITEMS = 185;
   localparam int STALL_PCT = 12;
   localparam int WATCHDOG_CYCLES = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int DIR_ROWS = 23;

   typedef enum logic [1:0] {HELD_NONE, HELD_PCT, HELD_DIGIT} held_type;

   typedef struct packed {
      req_type       req;
      logic          typed;
      logic [1:0]    n;
      rsp_type [2:0] res;
   } dir_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   held_type    held_count;
   logic [7:0]  held_digit;
   rsp_type     step_out [3];
   int          step_n;
   rsp_type     expected_q [$];
   logic [7:0]  text_q [$];
   dir_row_type dir_rows [DIR_ROWS];
   int          error_count = 0;
   int          idle_cycles = 0;
   int          random_sent = 0;
   bit          no_gaps = 1'b0;

   always #HALF_PERIOD clock = ~clock;

   percent_decoder_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // Bit 4 set means the byte is not a hex digit.
   function automatic logic [4:0] hex_nibble(input logic [7:0] b);
      if (b >= 8'h30 && b <= 8'h39) return {1'b0, 4'(b - 8'h30)};
      if (b >= 8'h41 && b <= 8'h46) return {1'b0, 4'(b - 8'h37)};
      if (b >= 8'h61 && b <= 8'h66) return {1'b0, 4'(b - 8'h57)};
      return 5'h10;
   endfunction

   function automatic logic [7:0] hex_char();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) return 8'(8'h30 + v);
      return 8'(($urandom_range(0, 1) != 0 ? 8'h41 : 8'h61) + v - 10);
   endfunction

   function automatic req_type rq(input logic [7:0] b, input logic l);
      req_type r;
      r.in_byte = b;
      r.in_last = l;
      return r;
   endfunction

   function automatic rsp_type rsp(input logic [7:0] b, input logic l);
      rsp_type r;
      r.out_byte = b;
      r.out_last = l;
      return r;
   endfunction

   function automatic dir_row_type row(input logic [7:0] b, input logic l, input logic t,
                                       input logic [1:0] n, input rsp_type r0 = '0,
                                       input rsp_type r1 = '0, input rsp_type r2 = '0);
      dir_row_type d;
      d.req = rq(b, l);
      d.typed = t;
      d.n = n;
      d.res = {r2, r1, r0};
      return d;
   endfunction

   task automatic emit(input logic [7:0] b, input logic l);
      step_out[step_n] = rsp(b, l);
      step_n++;
   endtask

   task automatic expect_rsp(input rsp_type r);
      expected_q.insert(expected_q.size(), r);
   endtask

   task automatic add_char(input logic [7:0] b);
      text_q.insert(text_q.size(), b);
   endtask

   // A byte seen with nothing held: a '%' before the end of the string is held.
   task automatic take_fresh(input req_type r);
      if (r.in_byte == PCT_CHAR && !r.in_last) begin
         held_count = HELD_PCT;
      end else begin
         emit(r.in_byte, r.in_last);
         held_count = HELD_NONE;
      end
   endtask

   task automatic decode_step(input req_type r);
      logic [4:0] lo;
      logic [4:0] hi;
      step_n = 0;
      lo = hex_nibble(r.in_byte);
      case (held_count)
         HELD_PCT: begin
            if (!r.in_last && !lo[4]) begin
               held_digit = r.in_byte;
               held_count = HELD_DIGIT;
            end else begin
               emit(PCT_CHAR, 1'b0);
               take_fresh(r);
            end
         end
         HELD_DIGIT: begin
            hi = hex_nibble(held_digit);
            if (!lo[4] && !hi[4]) begin
               emit({hi[3:0], lo[3:0]}, r.in_last);
               held_count = HELD_NONE;
            end else begin
               emit(PCT_CHAR, 1'b0);
               emit(held_digit, 1'b0);
               take_fresh(r);
            end
         end
         default: begin
            take_fresh(r);
         end
      endcase
   endtask

   task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
      $display("%0t: %s mismatch, got %h, expected %h", $time, what, got, want);
      error_count++;
   endtask

   // Offers one item, waits for its transfer and queues the results it causes.
   task automatic drive_item(input req_type r, input bit typed, input dir_row_type dr);
      @(negedge clock);
      while (!no_gaps && $urandom_range(0, 99) < STALL_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      decode_step(r);
      if (typed) begin
         for (int j = 0; j < dr.n; j++) expect_rsp(dr.res[j]);
      end else begin
         for (int j = 0; j < step_n; j++) expect_rsp(step_out[j]);
      end
   endtask

   // Strings are mostly valid escapes and plain bytes, with broken and cut-off
   // escapes mixed in.
   task automatic build_text();
      int pieces;
      int kind;
      text_q.delete();
      pieces = $urandom_range(1, 5);
      repeat (pieces) begin
         kind = $urandom_range(0, 9);
         if (kind <= 3) begin
            add_char(PCT_CHAR);
            add_char(hex_char());
            add_char(hex_char());
         end else if (kind == 4) begin
            add_char(PCT_CHAR);
            add_char(hex_char());
            add_char(8'($urandom_range(0, 255)));
         end else if (kind == 5) begin
            add_char(PCT_CHAR);
         end else begin
            add_char(8'($urandom_range(0, 255)));
         end
      end
   endtask

   always @(negedge clock) begin
      rsp_ready <= no_gaps || $urandom_range(0, 99) >= STALL_PCT;
   end

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            report("unexpected transfer, out_byte", rsp_payload.out_byte, 8'h00);
         end else begin
            want = expected_q.pop_front();
            if (rsp_payload.out_byte !== want.out_byte) begin
               report("out_byte", rsp_payload.out_byte, want.out_byte);
            end
            if (rsp_payload.out_last !== want.out_last) begin
               report("out_last", {7'd0, rsp_payload.out_last}, {7'd0, want.out_last});
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("tb: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      held_count = HELD_NONE;
      held_digit = 8'h00;

      // Rows with typed set carry their results; the others go through decode_step.
      dir_rows[0]  = row(8'h00, 1'b1, 1'b1, 2'd1, rsp(8'h00, 1'b1));
      dir_rows[1]  = row(8'hFF, 1'b0, 1'b1, 2'd1, rsp(8'hFF, 1'b0));
      dir_rows[2]  = row(PCT_CHAR, 1'b0, 1'b1, 2'd0);
      dir_rows[3]  = row(8'h34, 1'b0, 1'b1, 2'd0);
      dir_rows[4]  = row(8'h31, 1'b0, 1'b1, 2'd1, rsp(8'h41, 1'b0));
      dir_rows[5]  = row(PCT_CHAR, 1'b0, 1'b1, 2'd0);
      dir_rows[6]  = row(8'h66, 1'b0, 1'b1, 2'd0);
      dir_rows[7]  = row(8'h46, 1'b1, 1'b1, 2'd1, rsp(8'hFF, 1'b1));
      dir_rows[8]  = row(PCT_CHAR, 1'b0, 1'b1, 2'd0);
      dir_rows[9]  = row(8'h61, 1'b0, 1'b1, 2'd0);
      dir_rows[10] = row(8'h67, 1'b0, 1'b0, 2'd0);
      dir_rows[11] = row(PCT_CHAR, 1'b0, 1'b1, 2'd0);
      dir_rows[12] = row(8'h3A, 1'b0, 1'b1, 2'd2, rsp(PCT_CHAR, 1'b0), rsp(8'h3A, 1'b0));
      dir_rows[13] = row(PCT_CHAR, 1'b0, 1'b1, 2'd0);
      dir_rows[14] = row(PCT_CHAR, 1'b0, 1'b1, 2'd1, rsp(PCT_CHAR, 1'b0));
      dir_rows[15] = row(8'h32, 1'b0, 1'b1, 2'd0);
      dir_rows[16] = row(8'h30, 1'b0, 1'b0, 2'd0);
      dir_rows[17] = row(PCT_CHAR, 1'b0, 1'b1, 2'd0);
      dir_rows[18] = row(8'h39, 1'b1, 1'b1, 2'd2, rsp(PCT_CHAR, 1'b0), rsp(8'h39, 1'b1));
      dir_rows[19] = row(PCT_CHAR, 1'b1, 1'b1, 2'd1, rsp(PCT_CHAR, 1'b1));
      dir_rows[20] = row(PCT_CHAR, 1'b0, 1'b1, 2'd0);
      dir_rows[21] = row(8'h42, 1'b0, 1'b1, 2'd0);
      dir_rows[22] = row(PCT_CHAR, 1'b1, 1'b1, 2'd3, rsp(PCT_CHAR, 1'b0), rsp(8'h42, 1'b0),
                         rsp(PCT_CHAR, 1'b1));

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[k]) begin
         drive_item(dir_rows[k].req, dir_rows[k].typed, dir_rows[k]);
      end

      while (random_sent < RANDOM_ITEMS) begin
         build_text();
         foreach (text_q[k]) begin
            // A stretch in the middle runs with no input gaps and the receiver always ready.
            no_gaps = random_sent >= 60 && random_sent < 120;
            drive_item(rq(text_q[k], k == text_q.size() - 1), 1'b0, '0);
            random_sent++;
         end
      end
      no_gaps = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/pctdec_pkg.sv
src/pctdec_front.sv
src/pctdec_queue.sv
src/pctdec_back.sv
src/percent_decoder_core.sv
src/pctdec_checker.sv
sim/tb.sv
